### rtl/fdfb_pkg.sv
package fdfb_pkg;

    // Display geometry
    localparam int NUM_COLUMNS       = 16;
    localparam int COLUMN_BYTES      = 4;
    localparam int PANELS_TALL       = 2;
    localparam int PANEL_ROWS        = 16;
    localparam int PANEL_ACTIVE_ROWS = 14;
    localparam int DOTS_PER_BYTE     = 8;

    localparam int STORE_SIZE = NUM_COLUMNS * COLUMN_BYTES;
    localparam int ROW_BITS   = COLUMN_BYTES * DOTS_PER_BYTE;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int COL_W      = $clog2(NUM_COLUMNS);
    localparam int BYTE_W     = (COLUMN_BYTES > 1) ? $clog2(COLUMN_BYTES) : 1;

    // Command codes on the request side
    localparam logic [1:0] CMD_SET_PIXEL = 2'd0;
    localparam logic [1:0] CMD_CLEAR     = 2'd1;
    localparam logic [1:0] CMD_REFRESH   = 2'd2;

    // Serial actions on the result side
    typedef enum logic [2:0] {
        ACT_COL_SHIFT    = 3'd0,
        ACT_ROW_SHIFT    = 3'd1,
        ACT_STROBE       = 3'd2,
        ACT_ENABLE_BLACK = 3'd3,
        ACT_ENABLE_WHITE = 3'd4,
        ACT_ENABLE_NONE  = 3'd5
    } t_action;

    // Frame store access from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clear;
    } t_store_req;

    // Dot location of a set-pixel request
    typedef struct packed {
        logic              ok;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bitpos;
    } t_map;

    // Map panel coordinates to a store byte and bit
    function automatic t_map map_dot(input logic [3:0] x, input logic [4:0] y);
        t_map m;
        int   xi;
        int   yi;
        int   row;
        xi  = int'(x);
        yi  = int'(y);
        row = yi;
        for (int p = 1; p < PANELS_TALL; p++) begin
            if (yi >= p * PANEL_ACTIVE_ROWS) begin
                row = p * PANEL_ROWS + yi - p * PANEL_ACTIVE_ROWS;
            end
        end
        m.ok     = (xi < NUM_COLUMNS) && (yi < PANELS_TALL * PANEL_ACTIVE_ROWS)
                   && (row < ROW_BITS);
        m.col    = COL_W'(xi);
        m.addr   = ADDR_W'(xi * COLUMN_BYTES + row / DOTS_PER_BYTE);
        m.bitpos = 3'(row % DOTS_PER_BYTE);
        return m;
    endfunction

    // Pick the lowest set bit of the dirty mask
    function automatic logic [COL_W-1:0] lowest_dirty(input logic [NUM_COLUMNS-1:0] mask);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = NUM_COLUMNS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

    // Store address of one byte of a column
    function automatic logic [ADDR_W-1:0] byte_addr(input logic [COL_W-1:0] col, input int idx);
        return ADDR_W'(int'(col) * COLUMN_BYTES + idx);
    endfunction

endpackage

### rtl/fdfb_store.sv
module fdfb_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fdfb_pkg::t_store_req i_req,
    output logic [7:0]          o_rd_data
);

    logic [7:0]                     r_mem [fdfb_pkg::STORE_SIZE];
    logic [fdfb_pkg::STORE_SIZE-1:0] r_valid;
    logic [7:0]                     r_rd_data;
    logic                           r_rd_ok;

    // Write the byte array and register the read data
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Track written bytes; clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_valid[i_req.rd_addr];
            end
        end
    end

    // Read an unwritten byte as blank
    assign o_rd_data = r_rd_ok ? r_rd_data : 8'h00;

endmodule

### rtl/flipdot_framebuffer_refresh_top.sv
// Flip-dot frame buffer with column refresh.
// Request channel (i_s_*): tuser carries the command (set pixel, clear frame,
// refresh), tdata carries pixel_x, pixel_y and pixel_on. Result channel
// (o_m_*): one serial action per item, tuser is the action, tdata carries the
// shift bit and column index, tlast marks the final action (enable none).
// Set pixel reads one store byte, then writes it back with the dot modified,
// and returns nothing. Clear returns nothing. Refresh picks the
// lowest dirty column and streams NUM_COLUMNS + 8*COLUMN_BYTES + 4 actions
// (52 here), one per cycle while i_m_tready is high; the first action is
// loaded into the output register from the S_COL state. The rate is set by
// the action sequencer, which emits one action per cycle while the output
// register can load, and reads the column bytes one at a time through the
// single store read port. A refresh with nothing dirty returns nothing.
// The block takes no request while a command is in progress.
// After reset the store reads as all dark and every column is dirty.
// When the receiver stalls, the output register holds its action and the
// sequencer waits; no action is lost or repeated.
module flipdot_framebuffer_refresh_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // pixel_x[3:0], pixel_y[8:4], pixel_on[9], zero[15:10]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // shift_bit[0], column_index[4:1], zero[7:5]
    output logic [2:0]  o_m_tuser,   // action[2:0]
    output logic        o_m_tlast    // last_action
);

    localparam int CNT_W = (fdfb_pkg::COL_W > 2) ? fdfb_pkg::COL_W : 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_WR,
        S_COL,
        S_ROW,
        S_CTRL
    } t_state;

    t_state                            r_state, n_state;
    logic [fdfb_pkg::NUM_COLUMNS-1:0]  r_dirty, n_dirty;
    logic [fdfb_pkg::COL_W-1:0]        r_col, n_col;
    logic [CNT_W-1:0]                  r_cnt, n_cnt;
    logic [2:0]                        r_bit, n_bit;
    logic [fdfb_pkg::BYTE_W-1:0]       r_bidx, n_bidx;
    logic [7:0]                        r_byte, n_byte;
    fdfb_pkg::t_map                    r_map, n_map;
    logic                              r_on, n_on;
    logic                              r_out_valid, n_out_valid;
    fdfb_pkg::t_action                 r_out_action, n_out_action;
    logic                              r_out_bit, n_out_bit;
    logic [3:0]                        r_out_col, n_out_col;
    logic                              r_out_last, n_out_last;

    fdfb_pkg::t_store_req              w_req;
    logic [7:0]                        w_rd_data;
    logic                              w_accept;
    logic                              w_load;
    logic [31:0]                       w_col_ext;
    logic [7:0]                        w_mod;

    fdfb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = !r_out_valid || i_m_tready;
    assign w_col_ext  = 32'(r_col);

    // Modify the addressed dot of the byte read back
    always_comb begin
        w_mod = w_rd_data;
        w_mod[r_map.bitpos] = r_on;
    end

    // Sequence commands and serial actions
    always_comb begin
        n_state      = r_state;
        n_dirty      = r_dirty;
        n_col        = r_col;
        n_cnt        = r_cnt;
        n_bit        = r_bit;
        n_bidx       = r_bidx;
        n_byte       = r_byte;
        n_map        = r_map;
        n_on         = r_on;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_action = r_out_action;
        n_out_bit    = r_out_bit;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;
        w_req        = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_s_tuser)
                        fdfb_pkg::CMD_SET_PIXEL: begin
                            n_map         = fdfb_pkg::map_dot(i_s_tdata[3:0], i_s_tdata[8:4]);
                            n_on          = i_s_tdata[9];
                            w_req.rd_en   = n_map.ok;
                            w_req.rd_addr = n_map.addr;
                            n_state       = S_SET_WR;
                        end
                        fdfb_pkg::CMD_CLEAR: begin
                            w_req.clear = 1'b1;
                            n_dirty     = '1;
                        end
                        fdfb_pkg::CMD_REFRESH: begin
                            if (|r_dirty) begin
                                n_col         = fdfb_pkg::lowest_dirty(r_dirty);
                                n_cnt         = '0;
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = fdfb_pkg::byte_addr(n_col, 0);
                                n_state       = S_COL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SET_WR: begin
                if (r_map.ok) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_map.addr;
                    w_req.wr_data = w_mod;
                    n_dirty[r_map.col] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_COL: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_action = fdfb_pkg::ACT_COL_SHIFT;
                    n_out_bit    = (CNT_W'(r_col) == r_cnt);
                    n_out_col    = w_col_ext[3:0];
                    n_out_last   = 1'b0;
                    if (r_cnt == CNT_W'(fdfb_pkg::NUM_COLUMNS - 1)) begin
                        // Take byte 0 and fetch byte 1 ahead
                        n_byte  = w_rd_data;
                        n_bidx  = '0;
                        n_bit   = '0;
                        n_state = S_ROW;
                        if (fdfb_pkg::COLUMN_BYTES > 1) begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = fdfb_pkg::byte_addr(r_col, 1);
                        end
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_ROW: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_action = fdfb_pkg::ACT_ROW_SHIFT;
                    n_out_bit    = r_byte[r_bit];
                    n_out_last   = 1'b0;
                    n_bit        = r_bit + 1'b1;
                    if (r_bit == 3'd7) begin
                        if (r_bidx == fdfb_pkg::BYTE_W'(fdfb_pkg::COLUMN_BYTES - 1)) begin
                            n_cnt   = '0;
                            n_state = S_CTRL;
                        end else begin
                            // Advance to the next byte and prefetch the one after
                            n_byte = w_rd_data;
                            n_bidx = r_bidx + 1'b1;
                            if (int'(r_bidx) + 2 < fdfb_pkg::COLUMN_BYTES) begin
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = fdfb_pkg::byte_addr(r_col, int'(r_bidx) + 2);
                            end
                        end
                    end
                end
            end
            S_CTRL: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = 1'b0;
                    n_out_last  = 1'b0;
                    n_cnt       = r_cnt + 1'b1;
                    case (r_cnt[1:0])
                        2'd0:    n_out_action = fdfb_pkg::ACT_STROBE;
                        2'd1:    n_out_action = fdfb_pkg::ACT_ENABLE_BLACK;
                        2'd2:    n_out_action = fdfb_pkg::ACT_ENABLE_WHITE;
                        default: begin
                            n_out_action   = fdfb_pkg::ACT_ENABLE_NONE;
                            n_out_last     = 1'b1;
                            n_dirty[r_col] = 1'b0;
                            n_state        = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
        end
        r_col        <= n_col;
        r_cnt        <= n_cnt;
        r_bit        <= n_bit;
        r_bidx       <= n_bidx;
        r_byte       <= n_byte;
        r_map        <= n_map;
        r_on         <= n_on;
        r_out_action <= n_out_action;
        r_out_bit    <= n_out_bit;
        r_out_col    <= n_out_col;
        r_out_last   <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_col, r_out_bit};
    assign o_m_tuser  = r_out_action;
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/fdfb_checker.sv
module fdfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A set-pixel request occupies the block for its write cycle
    a_set_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == fdfb_pkg::CMD_SET_PIXEL)
        |=> !o_s_tready)
        else $error("request taken during a set-pixel write");

    // The run ends exactly on enable none
    a_last_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == fdfb_pkg::ACT_ENABLE_NONE)))
        else $error("last flag does not match enable none");

    // Only shift actions carry a data bit
    a_bit_shift_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != fdfb_pkg::ACT_COL_SHIFT
         && o_m_tuser != fdfb_pkg::ACT_ROW_SHIFT) |-> !o_m_tdata[0])
        else $error("data bit set on a control action");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready)
        |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result changed while stalled");

endmodule

bind flipdot_framebuffer_refresh_top fdfb_checker u_fdfb_checker (.*);

### dv/tb.sv
`timescale 1ns / 1ps

// One serial action on the panel bus, as the block should send it
typedef struct packed {
    fdfb_pkg::t_action act;
    logic              shift_bit;
    logic [3:0]        column;
    logic              last;
} t_panel_action;

// Tracks the frame store and dirty mask, and queues the actions each request should cause
class refresh_scoreboard;
    logic [7:0]                       dots [fdfb_pkg::STORE_SIZE];
    logic [fdfb_pkg::NUM_COLUMNS-1:0] dirty;
    t_panel_action                    pending_actions [$];
    int mismatches;
    int actions_checked;
    int dot_writes;
    int dots_dropped;
    int clears;
    int refreshes;
    int idle_refreshes;
    int unused_codes;

    function new();
        foreach (dots[i]) dots[i] = 8'h00;
        dirty = '1;
    endfunction

    function int pending();
        return pending_actions.size();
    endfunction

    // Queue one action of a refresh run
    function void push_action(fdfb_pkg::t_action act, logic bit_val, int col, logic last);
        t_panel_action a;
        a.act       = act;
        a.shift_bit = bit_val;
        a.column    = 4'(col);
        a.last      = last;
        pending_actions.push_back(a);
    endfunction

    // Update the store for one accepted request and queue its actions
    function void note_request(logic [1:0] cmd, logic [3:0] x, logic [4:0] y, logic on);
        int row;
        int idx;
        int col;
        case (cmd)
            fdfb_pkg::CMD_SET_PIXEL: begin
                dot_writes++;
                row = (int'(y) / fdfb_pkg::PANEL_ACTIVE_ROWS) * fdfb_pkg::PANEL_ROWS
                      + int'(y) % fdfb_pkg::PANEL_ACTIVE_ROWS;
                if (int'(x) >= fdfb_pkg::NUM_COLUMNS
                    || int'(y) >= fdfb_pkg::PANELS_TALL * fdfb_pkg::PANEL_ACTIVE_ROWS
                    || row >= fdfb_pkg::COLUMN_BYTES * 8) begin
                    dots_dropped++;
                end else begin
                    idx = int'(x) * fdfb_pkg::COLUMN_BYTES + row / 8;
                    dots[idx][row % 8] = on;
                    dirty[x] = 1'b1;
                end
            end
            fdfb_pkg::CMD_CLEAR: begin
                clears++;
                foreach (dots[i]) dots[i] = 8'h00;
                dirty = '1;
            end
            fdfb_pkg::CMD_REFRESH: begin
                refreshes++;
                col = -1;
                for (int i = fdfb_pkg::NUM_COLUMNS - 1; i >= 0; i--) begin
                    if (dirty[i]) col = i;
                end
                if (col < 0) begin
                    idle_refreshes++;
                end else begin
                    // one-hot column select, then the row bits byte by byte, LSB first
                    for (int i = 0; i < fdfb_pkg::NUM_COLUMNS; i++)
                        push_action(fdfb_pkg::ACT_COL_SHIFT, i == col, col, 1'b0);
                    for (int b = 0; b < fdfb_pkg::COLUMN_BYTES; b++)
                        for (int k = 0; k < 8; k++)
                            push_action(fdfb_pkg::ACT_ROW_SHIFT,
                                        dots[col * fdfb_pkg::COLUMN_BYTES + b][k], col, 1'b0);
                    push_action(fdfb_pkg::ACT_STROBE, 1'b0, col, 1'b0);
                    push_action(fdfb_pkg::ACT_ENABLE_BLACK, 1'b0, col, 1'b0);
                    push_action(fdfb_pkg::ACT_ENABLE_WHITE, 1'b0, col, 1'b0);
                    push_action(fdfb_pkg::ACT_ENABLE_NONE, 1'b0, col, 1'b1);
                    dirty[col] = 1'b0;
                end
            end
            default: unused_codes++;
        endcase
    endfunction

    // Compare one accepted action against the oldest queued one
    function void check_action(logic [2:0] tuser, logic [7:0] tdata, logic tlast);
        t_panel_action exp_a;
        actions_checked++;
        if (pending_actions.size() == 0) begin
            if (mismatches < 10)
                $display("[%0t] unexpected action: tuser=%0d tdata=%h tlast=%b",
                         $realtime, tuser, tdata, tlast);
            mismatches++;
            return;
        end
        exp_a = pending_actions.pop_front();
        if (tuser !== exp_a.act || tdata[0] !== exp_a.shift_bit
            || tdata[4:1] !== exp_a.column || tdata[7:5] !== 3'b000
            || tlast !== exp_a.last) begin
            if (mismatches < 10)
                $display("[%0t] action mismatch: exp act=%0d bit=%b col=%0d last=%b pad=0",
                         $realtime, exp_a.act, exp_a.shift_bit, exp_a.column, exp_a.last,
                         " | got act=%0d bit=%b col=%0d last=%b pad=%0d",
                         tuser, tdata[0], tdata[4:1], tlast, tdata[7:5]);
            mismatches++;
        end
    endfunction
endclass

module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // pixel_x[3:0], pixel_y[8:4], pixel_on[9], zero[15:10]
    logic [1:0]  i_s_tuser;   // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // shift_bit[0], column_index[4:1], zero[7:5]
    logic [2:0]  o_m_tuser;   // action[2:0]
    logic        o_m_tlast;

    refresh_scoreboard panel_sb;
    int  cycle_count;
    int  random_items;
    bit  src_burst;
    bit  sink_burst;

    flipdot_framebuffer_refresh_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    // Send one request after a random gap and hold it until taken
    task automatic send_request(logic [1:0] cmd, logic [3:0] x, logic [4:0] y, logic on);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'b000000, on, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        panel_sb.note_request(cmd, x, y, on);
    endtask

    task automatic set_dot(int x, int y, bit on);
        send_request(fdfb_pkg::CMD_SET_PIXEL, 4'(x), 5'(y), on);
    endtask

    // Accept actions with random stalls and check each one
    initial begin
        i_m_tready <= 1'b0;
        sink_burst = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            if ($urandom_range(0, 39) == 0) sink_burst = ~sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            panel_sb.check_action(o_m_tuser, o_m_tdata, o_m_tlast);
        end
    end

    // Reset, directed requests, random sequences, drain, verdict
    initial begin
        panel_sb   = new();
        src_burst  = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= fdfb_pkg::CMD_SET_PIXEL;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, panel seam, byte seam, rows past the active area, dot turned off
        set_dot(0, 0, 1'b1);
        set_dot(15, 27, 1'b1);
        set_dot(15, 13, 1'b1);
        set_dot(15, 14, 1'b1);
        set_dot(2, 7, 1'b1);
        set_dot(2, 8, 1'b1);
        set_dot(7, 31, 1'b1);
        set_dot(8, 28, 1'b0);
        set_dot(0, 0, 1'b0);
        send_request(CMD_UNUSED, 4'hF, 5'h1F, 1'b1);
        // drain every dirty column, then one refresh with nothing dirty
        repeat (fdfb_pkg::NUM_COLUMNS + 1)
            send_request(fdfb_pkg::CMD_REFRESH, 4'h0, 5'h00, 1'b0);

        // mostly a few dots followed by a refresh, the rest loose requests
        random_items = 0;
        while (random_items < 85) begin
            if ($urandom_range(0, 19) == 0) src_burst = ~src_burst;
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(fdfb_pkg::CMD_SET_PIXEL, 4'($urandom_range(0, 15)),
                                 5'($urandom_range(0, 27)), 1'($urandom));
                    random_items++;
                end
                send_request(fdfb_pkg::CMD_REFRESH, 4'($urandom), 5'($urandom),
                             1'($urandom));
                random_items++;
            end else begin
                logic [1:0] cmd;
                cmd = 2'($urandom_range(0, 3));
                send_request(cmd, 4'($urandom), 5'($urandom), 1'($urandom));
                if (cmd != CMD_UNUSED) random_items++;
            end
        end
        i_s_tvalid <= 1'b0;

        // wait out the last refresh, then watch for stray actions
        while (panel_sb.pending() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("requests: %0d dot writes (%0d off-panel), %0d clears, %0d unused codes",
                 panel_sb.dot_writes, panel_sb.dots_dropped, panel_sb.clears,
                 panel_sb.unused_codes);
        $display("refreshes: %0d (%0d with nothing dirty), %0d actions checked, %0d bad",
                 panel_sb.refreshes, panel_sb.idle_refreshes, panel_sb.actions_checked,
                 panel_sb.mismatches);
        if (panel_sb.mismatches == 0 && panel_sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
